FILE: src/eip4l4_pkg.sv
// Shared types, constants and helpers for the Ethernet/IPv4/L4 header parser.
// No dependencies.
package eip4l4_pkg;

   localparam int unsigned MAX_FRAME_DEF = 2048;
   localparam int unsigned OFS_W         = 12;

   localparam int unsigned ETH_HDR_LEN = 14;
   localparam int unsigned IP_MIN_LEN  = 20;
   localparam int unsigned UDP_HDR_LEN = 8;
   localparam int unsigned TCP_MIN_LEN = 20;

   localparam logic [15:0] ETYPE_IPV4 = 16'h0800;
   localparam logic [7:0]  PROTO_UDP  = 8'd17;
   localparam logic [7:0]  PROTO_TCP  = 8'd6;

   typedef enum logic [2:0] {
      ST_OK,
      ST_SHORT_ETH,
      ST_SHORT_IP,
      ST_BAD_SUM,
      ST_SHORT_UDP,
      ST_SHORT_TCP,
      ST_TOO_LONG
   } status_type;

   typedef enum logic [1:0] {
      L4_NONE,
      L4_UDP,
      L4_TCP
   } l4_kind_type;

   typedef struct packed {
      logic [7:0] data_byte;
      logic       last_byte;
   } beat_type;

   typedef struct packed {
      status_type       status;
      logic             is_ipv4;
      l4_kind_type      l4_kind;
      logic [7:0]       ip_protocol;
      logic [OFS_W-1:0] l4_offset;
      logic [OFS_W-1:0] payload_offset;
      logic [OFS_W-1:0] payload_length;
   } result_type;

   // Header length in bytes from a 4-bit word count, floored at the 20-byte minimum.
   function automatic logic [5:0] hdr_bytes(input logic [3:0] words);
      logic [5:0] b;
      b = {words, 2'b00};
      return (b < 6'(IP_MIN_LEN)) ? 6'(IP_MIN_LEN) : b;
   endfunction

endpackage

FILE: src/eip4l4_parse.sv
// Per-byte header parse state and end-of-frame result computation.
// Depends on eip4l4_pkg.
module eip4l4_parse #(
   parameter int unsigned MAX_FRAME = eip4l4_pkg::MAX_FRAME_DEF
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   step,
   input  eip4l4_pkg::beat_type   beat,
   output eip4l4_pkg::result_type result
);
   import eip4l4_pkg::*;

   localparam int unsigned POS_W  = $clog2(MAX_FRAME + 1);
   localparam int unsigned CALC_W = ((POS_W > 8) ? POS_W : 8) + 1;

   logic [POS_W-1:0] pos_ff,   pos_in;
   logic [15:0]      ether_ff, ether_in;
   logic [5:0]       ihb_ff,   ihb_in;
   logic [7:0]       proto_ff, proto_in;
   logic [15:0]      sum_ff,   sum_in;
   logic [7:0]       hold_ff,  hold_in;
   logic [5:0]       thb_ff,   thb_in;
   status_type       err_ff,   err_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff   <= '0;
         ether_ff <= '0;
         ihb_ff   <= '0;
         proto_ff <= '0;
         sum_ff   <= '0;
         hold_ff  <= '0;
         thb_ff   <= '0;
         err_ff   <= ST_OK;
      end else begin
         pos_ff   <= pos_in;
         ether_ff <= ether_in;
         ihb_ff   <= ihb_in;
         proto_ff <= proto_in;
         sum_ff   <= sum_in;
         hold_ff  <= hold_in;
         thb_ff   <= thb_in;
         err_ff   <= err_in;
      end
   end

   always_comb begin
      logic [POS_W-1:0] n_pos;
      logic [15:0]      n_ether;
      logic [5:0]       n_ihb;
      logic [7:0]       n_proto;
      logic [15:0]      n_sum;
      logic [7:0]       n_hold;
      logic [5:0]       n_thb;
      status_type       n_err;
      logic [POS_W-1:0] q;
      logic [POS_W-1:0] r;
      logic [5:0]       ihb_cur;
      logic [16:0]      sum_wide;
      logic [15:0]      sum_new;
      logic [CALC_W-1:0] len;
      logic [CALC_W-1:0] l4;
      logic [CALC_W-1:0] udp_end;
      logic [CALC_W-1:0] tcp_end;
      logic [CALC_W-1:0] poff;
      logic [5:0]       ihb_fl;
      logic [5:0]       thb_fl;

      n_pos   = pos_ff;
      n_ether = ether_ff;
      n_ihb   = ihb_ff;
      n_proto = proto_ff;
      n_sum   = sum_ff;
      n_hold  = hold_ff;
      n_thb   = thb_ff;
      n_err   = err_ff;
      q        = pos_ff - POS_W'(ETH_HDR_LEN);
      ihb_cur  = ihb_ff;
      r        = q - POS_W'(ihb_cur);
      sum_wide = {1'b0, sum_ff} + {1'b0, hold_ff, beat.data_byte};
      sum_new  = sum_ff;

      if (step) begin
         if (pos_ff >= POS_W'(MAX_FRAME)) begin
            if (err_ff == ST_OK) begin
               n_err = ST_TOO_LONG;
            end
         end else begin
            n_pos = pos_ff + POS_W'(1);
            if (err_ff == ST_OK) begin
               if (pos_ff == POS_W'(12)) begin
                  n_ether = {beat.data_byte, 8'h00};
               end else if (pos_ff == POS_W'(13)) begin
                  n_ether = {ether_ff[15:8], beat.data_byte};
               end else if (pos_ff >= POS_W'(ETH_HDR_LEN) && ether_ff == ETYPE_IPV4) begin
                  if (q == '0) begin
                     ihb_cur = hdr_bytes(beat.data_byte[3:0]);
                     n_ihb   = ihb_cur;
                  end
                  r = q - POS_W'(ihb_cur);
                  if (q < POS_W'(ihb_cur)) begin
                     if (q == POS_W'(9)) begin
                        n_proto = beat.data_byte;
                     end
                     if (!q[0]) begin
                        n_hold = beat.data_byte;
                     end else begin
                        sum_new = sum_wide[15:0] + 16'(sum_wide[16]);
                        n_sum   = sum_new;
                     end
                     if (q == POS_W'(ihb_cur - 6'd1) && sum_new != 16'hFFFF) begin
                        n_err = ST_BAD_SUM;
                     end
                  end else if (proto_ff == PROTO_UDP) begin
                     if (r == '0) begin
                        n_thb = 6'(UDP_HDR_LEN);
                     end
                  end else if (proto_ff == PROTO_TCP) begin
                     if (r == '0) begin
                        n_thb = 6'(TCP_MIN_LEN);
                     end
                     if (r == POS_W'(12)) begin
                        n_thb = hdr_bytes(beat.data_byte[7:4]);
                     end
                  end
               end
            end
         end
      end

      // end-of-frame summary from the updated state
      len     = CALC_W'(n_pos);
      ihb_fl  = (n_ihb == '0) ? 6'(IP_MIN_LEN) : n_ihb;
      thb_fl  = (n_thb < 6'(TCP_MIN_LEN)) ? 6'(TCP_MIN_LEN) : n_thb;
      l4      = CALC_W'(ETH_HDR_LEN) + CALC_W'(ihb_fl);
      udp_end = l4 + CALC_W'(UDP_HDR_LEN);
      tcp_end = l4 + CALC_W'(thb_fl);
      poff    = '0;

      result = '0;
      result.status  = ST_OK;
      result.l4_kind = L4_NONE;
      if (n_err != ST_OK) begin
         result.status = n_err;
      end else if (len < CALC_W'(ETH_HDR_LEN)) begin
         result.status = ST_SHORT_ETH;
      end else if (n_ether != ETYPE_IPV4) begin
         poff = CALC_W'(ETH_HDR_LEN);
      end else if (len < l4) begin
         result.status = ST_SHORT_IP;
      end else begin
         result.is_ipv4     = 1'b1;
         result.ip_protocol = n_proto;
         if (n_proto == PROTO_UDP) begin
            if (len < udp_end) begin
               result.status = ST_SHORT_UDP;
            end else begin
               result.l4_kind   = L4_UDP;
               result.l4_offset = OFS_W'(l4);
               poff             = udp_end;
            end
         end else if (n_proto == PROTO_TCP) begin
            if (len < tcp_end) begin
               result.status = ST_SHORT_TCP;
            end else begin
               result.l4_kind   = L4_TCP;
               result.l4_offset = OFS_W'(l4);
               poff             = tcp_end;
            end
         end else begin
            poff = l4;
         end
      end
      if (result.status == ST_OK) begin
         result.payload_offset = OFS_W'(poff);
         result.payload_length = OFS_W'(len - poff);
      end

      if (step && beat.last_byte) begin
         pos_in   = '0;
         ether_in = '0;
         ihb_in   = '0;
         proto_in = '0;
         sum_in   = '0;
         hold_in  = '0;
         thb_in   = '0;
         err_in   = ST_OK;
      end else begin
         pos_in   = n_pos;
         ether_in = n_ether;
         ihb_in   = n_ihb;
         proto_in = n_proto;
         sum_in   = n_sum;
         hold_in  = n_hold;
         thb_in   = n_thb;
         err_in   = n_err;
      end
   end

endmodule

FILE: src/eip4l4_out.sv
// Result register with valid/stall handshake toward the consumer.
// Depends on eip4l4_pkg.
module eip4l4_out (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   load,
   input  eip4l4_pkg::result_type result,
   input  logic                   rsp_stall,
   output logic                   rsp_valid,
   output logic                   busy,
   output eip4l4_pkg::result_type rsp_data
);
   import eip4l4_pkg::*;

   logic       valid_ff, valid_in;
   result_type data_ff,  data_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      data_ff <= data_in;
   end

   always_comb begin
      valid_in = valid_ff;
      data_in  = data_ff;
      if (load) begin
         valid_in = 1'b1;
         data_in  = result;
      end else if (!rsp_stall) begin
         valid_in = 1'b0;
      end
   end

   assign busy      = valid_ff && rsp_stall;
   assign rsp_valid = valid_ff;
   assign rsp_data  = data_ff;

endmodule

FILE: src/eth_ipv4_l4_header_parser.sv
// Ethernet/IPv4/UDP/TCP header parser, one frame byte per beat.
// A last byte passes the input register, then the result register, before rsp_valid
// rises; a result register that is full and stalled holds it in the input register.
// Throughput: one byte per cycle; the byte register advances unless a last byte
// meets a result register that is full and stalled.
// Reset (synchronous, active high) clears parse state and both valid flags.
// Depends on eip4l4_pkg, eip4l4_parse, eip4l4_out.
module eth_ipv4_l4_header_parser #(
   parameter int unsigned MAX_FRAME = eip4l4_pkg::MAX_FRAME_DEF
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [7:0]  req_data_byte,
   input  logic        req_last_byte,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [2:0]  rsp_status,
   output logic        rsp_is_ipv4,
   output logic [1:0]  rsp_l4_kind,
   output logic [7:0]  rsp_ip_protocol,
   output logic [11:0] rsp_l4_offset,
   output logic [11:0] rsp_payload_offset,
   output logic [11:0] rsp_payload_length
);
   import eip4l4_pkg::*;

   logic       in_valid_ff, in_valid_in;
   beat_type   in_beat_ff,  in_beat_in;
   logic       advance;
   logic       out_busy;
   result_type result;
   result_type rsp_data;

   assign advance   = in_valid_ff && !(in_beat_ff.last_byte && out_busy);
   assign req_stall = in_valid_ff && !advance;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else begin
         in_valid_ff <= in_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      in_beat_ff <= in_beat_in;
   end

   always_comb begin
      in_valid_in = in_valid_ff;
      in_beat_in  = in_beat_ff;
      if (req_valid && !req_stall) begin
         in_valid_in          = 1'b1;
         in_beat_in.data_byte = req_data_byte;
         in_beat_in.last_byte = req_last_byte;
      end else if (advance) begin
         in_valid_in = 1'b0;
      end
   end

   eip4l4_parse #(
      .MAX_FRAME (MAX_FRAME)
   ) u_parse (
      .clock  (clock),
      .reset  (reset),
      .step   (advance),
      .beat   (in_beat_ff),
      .result (result)
   );

   eip4l4_out u_out (
      .clock     (clock),
      .reset     (reset),
      .load      (advance && in_beat_ff.last_byte),
      .result    (result),
      .rsp_stall (rsp_stall),
      .rsp_valid (rsp_valid),
      .busy      (out_busy),
      .rsp_data  (rsp_data)
   );

   assign rsp_status         = rsp_data.status;
   assign rsp_is_ipv4        = rsp_data.is_ipv4;
   assign rsp_l4_kind        = rsp_data.l4_kind;
   assign rsp_ip_protocol    = rsp_data.ip_protocol;
   assign rsp_l4_offset      = rsp_data.l4_offset;
   assign rsp_payload_offset = rsp_data.payload_offset;
   assign rsp_payload_length = rsp_data.payload_length;

endmodule

FILE: test/tb_eth_ipv4_l4_header_parser.sv
// Testbench for eth_ipv4_l4_header_parser: directed and random Ethernet frames,
// driven a byte per beat and checked against a built-in frame tracker.
// Depends on eip4l4_pkg and the parser RTL.
`timescale 1ns / 100ps

module tb_eth_ipv4_l4_header_parser;
   import eip4l4_pkg::*;

   localparam int unsigned FRAME_CAP    = MAX_FRAME_DEF;
   localparam int unsigned TOTAL_BEATS  = 1950;
   localparam int unsigned TAIL_BEATS   = 400;

   typedef logic [7:0] octet_q[$];

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_stall;
   logic [7:0]  req_data_byte = 8'h00;
   logic        req_last_byte = 1'b0;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   logic [2:0]  rsp_status;
   logic        rsp_is_ipv4;
   logic [1:0]  rsp_l4_kind;
   logic [7:0]  rsp_ip_protocol;
   logic [11:0] rsp_l4_offset;
   logic [11:0] rsp_payload_offset;
   logic [11:0] rsp_payload_length;

   beat_type    pending_beats[$];
   beat_type    next_beat;
   result_type  expected_summaries[$];
   result_type  want;

   // frame tracker state
   int unsigned frame_bytes = 0;
   logic [15:0] etype = 16'h0000;
   int unsigned ip_hlen = 0;
   logic [7:0]  ip_proto = 8'h00;
   int unsigned hdr_sum = 0;
   logic [7:0]  word_hi = 8'h00;
   int unsigned l4_hlen = 0;
   status_type  first_err = ST_OK;

   int unsigned errors = 0;
   int unsigned results_checked = 0;
   int unsigned frames_queued = 0;
   int unsigned send_gap = 0;
   int unsigned stall_left = 0;
   int unsigned cycle_count = 0;
   int unsigned cycle_limit = 32'hFFFF_FFFF;

   eth_ipv4_l4_header_parser #(.MAX_FRAME(FRAME_CAP)) uut (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_stall(req_stall),
      .req_data_byte(req_data_byte),
      .req_last_byte(req_last_byte),
      .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall),
      .rsp_status(rsp_status),
      .rsp_is_ipv4(rsp_is_ipv4),
      .rsp_l4_kind(rsp_l4_kind),
      .rsp_ip_protocol(rsp_ip_protocol),
      .rsp_l4_offset(rsp_l4_offset),
      .rsp_payload_offset(rsp_payload_offset),
      .rsp_payload_length(rsp_payload_length)
   );

   always #1 clock = ~clock;

   function automatic int unsigned floor20(input int unsigned v);
      return (v < 20) ? 20 : v;
   endfunction

   // Advance the tracker by one accepted byte; a last byte yields a summary.
   task automatic track_frame_byte(input logic [7:0] b, input logic last);
      int unsigned q, r, s, l4, thl, l4off, poff;
      logic        ipv4;
      logic [7:0]  proto;
      l4_kind_type kind;
      status_type  st;
      result_type  res;
      if (frame_bytes >= FRAME_CAP) begin
         if (first_err == ST_OK) first_err = ST_TOO_LONG;
      end else begin
         if (first_err == ST_OK) begin
            if (frame_bytes == 12) begin
               etype = {b, 8'h00};
            end else if (frame_bytes == 13) begin
               etype[7:0] = b;
            end else if (frame_bytes >= ETH_HDR_LEN && etype == ETYPE_IPV4) begin
               q = frame_bytes - ETH_HDR_LEN;
               if (q == 0) ip_hlen = floor20(int'(b[3:0]) * 4);
               if (q < ip_hlen) begin
                  if (q == 9) ip_proto = b;
                  if (q[0] == 1'b0) begin
                     word_hi = b;
                  end else begin
                     s = hdr_sum + {word_hi, b};
                     hdr_sum = (s & 32'hFFFF) + (s >> 16);
                  end
                  if (q == ip_hlen - 1 && hdr_sum != 32'hFFFF) first_err = ST_BAD_SUM;
               end else begin
                  r = q - ip_hlen;
                  if (ip_proto == PROTO_UDP) begin
                     if (r == 0) l4_hlen = UDP_HDR_LEN;
                  end else if (ip_proto == PROTO_TCP) begin
                     if (r == 0) l4_hlen = TCP_MIN_LEN;
                     if (r == 12) l4_hlen = floor20(int'(b[7:4]) * 4);
                  end
               end
            end
         end
         frame_bytes++;
      end
      if (last) begin
         st = first_err;
         ipv4 = 1'b0;
         proto = 8'h00;
         kind = L4_NONE;
         l4off = 0;
         poff = 0;
         if (st == ST_OK) begin
            if (frame_bytes < ETH_HDR_LEN) begin
               st = ST_SHORT_ETH;
            end else if (etype != ETYPE_IPV4) begin
               poff = ETH_HDR_LEN;
            end else begin
               l4 = ETH_HDR_LEN + floor20(ip_hlen);
               if (frame_bytes < l4) begin
                  st = ST_SHORT_IP;
               end else begin
                  ipv4 = 1'b1;
                  proto = ip_proto;
                  if (proto == PROTO_UDP) begin
                     if (frame_bytes < l4 + UDP_HDR_LEN) begin
                        st = ST_SHORT_UDP;
                     end else begin
                        kind = L4_UDP;
                        l4off = l4;
                        poff = l4 + UDP_HDR_LEN;
                     end
                  end else if (proto == PROTO_TCP) begin
                     thl = floor20(l4_hlen);
                     if (frame_bytes < l4 + thl) begin
                        st = ST_SHORT_TCP;
                     end else begin
                        kind = L4_TCP;
                        l4off = l4;
                        poff = l4 + thl;
                     end
                  end else begin
                     poff = l4;
                  end
               end
            end
         end
         res.status = st;
         res.is_ipv4 = ipv4;
         res.ip_protocol = proto;
         if (st == ST_OK) begin
            res.l4_kind = kind;
            res.l4_offset = 12'(l4off);
            res.payload_offset = 12'(poff);
            res.payload_length = 12'(frame_bytes - poff);
         end else begin
            res.l4_kind = L4_NONE;
            res.l4_offset = '0;
            res.payload_offset = '0;
            res.payload_length = '0;
            if (st != ST_SHORT_UDP && st != ST_SHORT_TCP) begin
               res.is_ipv4 = 1'b0;
               res.ip_protocol = 8'h00;
            end
         end
         expected_summaries.push_back(res);
         frame_bytes = 0;
         etype = 16'h0000;
         ip_hlen = 0;
         ip_proto = 8'h00;
         hdr_sum = 0;
         word_hi = 8'h00;
         l4_hlen = 0;
         first_err = ST_OK;
      end
   endtask

   task automatic check_field(input string name, input logic [15:0] exp_v,
                              input logic [15:0] act_v);
      if (act_v !== exp_v) begin
         errors++;
         $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, exp_v, act_v);
      end
   endtask

   // IPv4 frame with random addresses, fields and payload; checksum fixed up
   // unless a bad one is asked for.
   task automatic ip_frame(input logic [3:0] ver, input logic [3:0] ihl,
                           input logic [7:0] proto, input logic [3:0] doff,
                           input int unsigned pay, input bit good_sum, output octet_q fr);
      int unsigned hl, acc, start;
      logic [15:0] ck;
      fr = {};
      repeat (12) fr.push_back(8'($urandom));
      fr.push_back(ETYPE_IPV4[15:8]);
      fr.push_back(ETYPE_IPV4[7:0]);
      hl = floor20(int'(ihl) * 4);
      repeat (hl) fr.push_back(8'($urandom));
      fr[14] = {ver, ihl};
      fr[23] = proto;
      fr[24] = 8'h00;
      fr[25] = 8'h00;
      acc = 0;
      for (int i = 0; i < hl; i += 2) begin
         acc = acc + {fr[14 + i], fr[15 + i]};
         acc = (acc & 32'hFFFF) + (acc >> 16);
      end
      ck = ~acc[15:0];
      if (!good_sum) ck = ck ^ (16'h0001 << $urandom_range(0, 15));
      fr[24] = ck[15:8];
      fr[25] = ck[7:0];
      if (proto == PROTO_UDP) begin
         repeat (UDP_HDR_LEN) fr.push_back(8'($urandom));
      end else if (proto == PROTO_TCP) begin
         start = fr.size();
         repeat (floor20(int'(doff) * 4)) fr.push_back(8'($urandom));
         fr[start + 12] = {doff, 4'($urandom)};
      end
      repeat (pay) fr.push_back(8'($urandom));
   endtask

   task automatic raw_frame(input int unsigned len, input logic [15:0] et,
                            input bit set_et, output octet_q fr);
      fr = {};
      repeat (len) fr.push_back(8'($urandom));
      if (set_et && len >= ETH_HDR_LEN) begin
         fr[12] = et[15:8];
         fr[13] = et[7:0];
      end
   endtask

   task automatic trim(inout octet_q fr, input int unsigned n);
      while (fr.size() > n) void'(fr.pop_back());
   endtask

   task automatic queue_frame(input octet_q fr);
      beat_type bt;
      foreach (fr[i]) begin
         bt.data_byte = fr[i];
         bt.last_byte = (i == fr.size() - 1);
         pending_beats.push_back(bt);
      end
      frames_queued++;
   endtask

   // byte driver
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
         send_gap = 0;
      end else begin
         if (req_valid && !req_stall) track_frame_byte(req_data_byte, req_last_byte);
         if (!req_valid || !req_stall) begin
            if (send_gap > 0) begin
               send_gap--;
               req_valid <= 1'b0;
            end else if (pending_beats.size() > 0) begin
               next_beat = pending_beats.pop_front();
               req_valid <= 1'b1;
               req_data_byte <= next_beat.data_byte;
               req_last_byte <= next_beat.last_byte;
               if (pending_beats.size() >= TAIL_BEATS && $urandom_range(0, 7) == 0)
                  send_gap = $urandom_range(1, 14);
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // result monitor and stall generator
   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
         stall_left = 0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (expected_summaries.size() == 0) begin
               errors++;
               $display("%0t: result with none expected, actual status %0d",
                        $time, rsp_status);
            end else begin
               want = expected_summaries.pop_front();
               results_checked++;
               check_field("status", want.status, rsp_status);
               check_field("is_ipv4", want.is_ipv4, rsp_is_ipv4);
               check_field("l4_kind", want.l4_kind, rsp_l4_kind);
               check_field("ip_protocol", want.ip_protocol, rsp_ip_protocol);
               check_field("l4_offset", want.l4_offset, rsp_l4_offset);
               check_field("payload_offset", want.payload_offset, rsp_payload_offset);
               check_field("payload_length", want.payload_length, rsp_payload_length);
            end
         end
         if (stall_left > 0) begin
            stall_left--;
            rsp_stall <= 1'b1;
         end else if (pending_beats.size() >= TAIL_BEATS && $urandom_range(0, 9) == 0) begin
            stall_left = $urandom_range(1, 14) - 1;
            rsp_stall <= 1'b1;
         end else begin
            rsp_stall <= 1'b0;
         end
      end
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > cycle_limit) begin
         $display("timeout after %0d cycles, %0d results outstanding",
                  cycle_count, expected_summaries.size());
         $display("FAIL");
         $finish;
      end
   end

   initial begin
      octet_q      fr;
      int unsigned total_beats, rnd_frames, pick;
      logic [3:0]  ihl, doff, ver;
      logic [7:0]  proto;

      // directed frames
      raw_frame(1, 16'h0000, 1'b0, fr);           queue_frame(fr);
      raw_frame(13, 16'h0000, 1'b0, fr);          queue_frame(fr);
      raw_frame(14, 16'h86DD, 1'b1, fr);          queue_frame(fr);
      raw_frame(14, ETYPE_IPV4, 1'b1, fr);        queue_frame(fr);
      raw_frame(60, 16'h0008, 1'b1, fr);          queue_frame(fr);
      raw_frame(33, ETYPE_IPV4, 1'b1, fr);        queue_frame(fr);
      ip_frame(4'd4, 4'd5, PROTO_UDP, 4'd0, 0, 1'b1, fr);    queue_frame(fr);
      ip_frame(4'd4, 4'd5, PROTO_UDP, 4'd0, 0, 1'b1, fr);
      trim(fr, 41);                                          queue_frame(fr);
      ip_frame(4'd4, 4'd5, PROTO_TCP, 4'd5, 10, 1'b1, fr);   queue_frame(fr);
      ip_frame(4'd4, 4'd15, PROTO_TCP, 4'd15, 3, 1'b1, fr);  queue_frame(fr);
      ip_frame(4'd4, 4'd0, PROTO_TCP, 4'd0, 0, 1'b1, fr);    queue_frame(fr);
      ip_frame(4'd4, 4'd5, PROTO_TCP, 4'd15, 0, 1'b1, fr);
      trim(fr, 64);                                          queue_frame(fr);
      ip_frame(4'd4, 4'd5, PROTO_TCP, 4'd5, 0, 1'b1, fr);
      trim(fr, 39);                                          queue_frame(fr);
      ip_frame(4'd4, 4'd15, PROTO_UDP, 4'd0, 0, 1'b1, fr);
      trim(fr, 50);                                          queue_frame(fr);
      ip_frame(4'd4, 4'd5, 8'd1, 4'd0, 12, 1'b1, fr);        queue_frame(fr);
      ip_frame(4'd4, 4'd5, PROTO_UDP, 4'd0, 4, 1'b0, fr);    queue_frame(fr);
      ip_frame(4'd4, 4'd6, PROTO_TCP, 4'd5, 0, 1'b0, fr);
      trim(fr, 41);                                          queue_frame(fr);
      ip_frame(4'd0, 4'd5, PROTO_UDP, 4'd0, 7, 1'b1, fr);    queue_frame(fr);
      ip_frame(4'd15, 4'd7, 8'd255, 4'd0, 5, 1'b1, fr);      queue_frame(fr);
      ip_frame(4'd4, 4'd5, 8'd0, 4'd0, 0, 1'b1, fr);         queue_frame(fr);

      // random frames, mostly IPv4 with random content
      total_beats = TOTAL_BEATS;
      rnd_frames = 0;
      while (pending_beats.size() < total_beats) begin
         pick = $urandom_range(0, 9);
         if (pick < 6) begin
            ver = ($urandom_range(0, 7) == 0) ? 4'($urandom) : 4'd4;
            ihl = ($urandom_range(0, 3) == 0) ? 4'($urandom) : 4'd5;
            doff = ($urandom_range(0, 3) == 0) ? 4'($urandom) : 4'd5;
            pick = $urandom_range(0, 9);
            proto = (pick < 4) ? PROTO_UDP : (pick < 8) ? PROTO_TCP : 8'($urandom);
            ip_frame(ver, ihl, proto, doff, $urandom_range(0, 20),
                     $urandom_range(0, 9) != 0, fr);
            if ($urandom_range(0, 6) == 0) trim(fr, $urandom_range(1, fr.size() - 1));
         end else if (pick < 8) begin
            raw_frame($urandom_range(14, 50), 16'($urandom), 1'b1, fr);
         end else begin
            raw_frame($urandom_range(1, 40), ETYPE_IPV4, $urandom_range(0, 1), fr);
         end
         queue_frame(fr);
         rnd_frames++;
      end
      cycle_limit = 64 * pending_beats.size() + 10000;

      repeat (9) @(posedge clock);
      reset <= 1'b0;
      while (pending_beats.size() > 0 || req_valid || expected_summaries.size() > 0)
         @(posedge clock);
      repeat (20) @(posedge clock);

      $display("%0d frames sent (%0d random), incl. truncated and bad-checksum headers",
               frames_queued, rnd_frames);
      $display("%0d frame summaries checked, %0d mismatches", results_checked, errors);
      if (errors == 0) begin
         $display("PASS");
      end else begin
         $display("FAIL");
      end
      $finish;
   end

endmodule
